// ===== rtl/core/av1_skip_mode_reference_search_macros.svh =====
// Assertion helpers for the skip-mode search RTL.
`ifndef AV1_SKIP_MODE_REFERENCE_SEARCH_MACROS_SVH
`define AV1_SKIP_MODE_REFERENCE_SEARCH_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SMRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define SMRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/av1_smrs_pkg.sv =====
package av1_smrs_pkg;

    localparam int NUM_SLOTS     = 8;
    localparam int NUM_REFS      = 7;
    localparam int MAX_HINT_BITS = 8;

    localparam int HINT_W     = 8;
    localparam int SLOT_W     = 3;
    localparam int POS_W      = 3;
    localparam int NUM_PICKS  = 7;
    localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
    localparam int PC_W       = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER_HINT_ENABLE = 1'b0,
        REG_HINT_BITS         = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_IDLE  = 3'd1,
        OP_SCAN1 = 3'd2,
        OP_SCAN2 = 3'd3,
        OP_EMIT  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_START = 3'd2,
        C_OFF      = 3'd3,
        C_MORE     = 3'd4,
        C_NO_SCAN2 = 3'd5,
        C_OUT_BUSY = 3'd6
    } cond_sel_t;

    localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
    localparam logic [PC_W-1:0] PC_CHECK  = 3'd1;
    localparam logic [PC_W-1:0] PC_SCAN1  = 3'd2;
    localparam logic [PC_W-1:0] PC_DECIDE = 3'd3;
    localparam logic [PC_W-1:0] PC_SCAN2  = 3'd4;
    localparam logic [PC_W-1:0] PC_EMIT   = 3'd5;
    localparam logic [PC_W-1:0] PC_RETURN = 3'd6;

    typedef struct packed {
        op_t             op;
        cond_sel_t       cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic start;
        logic off;
        logic more;
        logic no_scan2;
        logic out_busy;
    } useq_flags_t;

    // When the condition holds the sequencer jumps to target, otherwise it steps on.
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            PC_WAIT:   w = '{op: OP_IDLE,  cond: C_NO_START, target: PC_WAIT};
            PC_CHECK:  w = '{op: OP_NOP,   cond: C_OFF,      target: PC_EMIT};
            PC_SCAN1:  w = '{op: OP_SCAN1, cond: C_MORE,     target: PC_SCAN1};
            PC_DECIDE: w = '{op: OP_NOP,   cond: C_NO_SCAN2, target: PC_EMIT};
            PC_SCAN2:  w = '{op: OP_SCAN2, cond: C_MORE,     target: PC_SCAN2};
            PC_EMIT:   w = '{op: OP_EMIT,  cond: C_OUT_BUSY, target: PC_EMIT};
            PC_RETURN: w = '{op: OP_NOP,   cond: C_ALWAYS,   target: PC_WAIT};
            default:   w = '{op: OP_NOP,   cond: C_ALWAYS,   target: PC_WAIT};
        endcase
        return w;
    endfunction

    // Signed distance a - b wrapped to the given hint width (1 to MAX_HINT_BITS).
    function automatic logic signed [HINT_W:0] rel_dist(input logic [HINT_W-1:0] a,
                                                        input logic [HINT_W-1:0] b,
                                                        input logic [CFG_DATA_W-1:0] bits);
        logic [HINT_W:0]   one;
        logic [HINT_W-1:0] mask;
        logic [HINT_W-1:0] half;
        logic [HINT_W-1:0] d;
        one  = (HINT_W+1)'(1);
        mask = HINT_W'((one << bits) - one);
        half = HINT_W'(one << (bits - CFG_DATA_W'(1)));
        d    = (a - b) & mask;
        if ((d & half) != '0) begin
            return $signed({1'b0, d} - ({1'b0, half} << 1));
        end
        return $signed({1'b0, d});
    endfunction

endpackage

// ===== rtl/core/av1_smrs_useq.sv =====
module av1_smrs_useq
    import av1_smrs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  useq_flags_t flags,
    output uword_t      ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            jump;

    assign ctrl = ucode_rom(pc_reg);

    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_START: jump = !flags.start;
            C_OFF:      jump = flags.off;
            C_MORE:     jump = flags.more;
            C_NO_SCAN2: jump = flags.no_scan2;
            C_OUT_BUSY: jump = flags.out_busy;
            default:    jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ===== rtl/core/av1_skip_mode_reference_search.sv =====
// Channel   Direction  Handshake          Beat
// s_        in         s_valid/s_ready    load of one slot hint, or one frame to evaluate
// m_        out        m_valid/m_ready    skip-mode result of one evaluated frame
// cfg_      in         cfg_wr_en          order_hint_enable or hint_bits
//
// A load beat is taken while idle and gives no result.
// An evaluate beat runs a first pass over the reference positions, then a second pass
// unless a backward reference is found or no forward one, and skips both when the search
// is off; each pass scans one position per cycle, and no new beat is taken until it ends.
// Reset clears the slot hints, sets order_hint_enable and sets hint_bits to MAX_HINT_BITS.
// A result that waits on m_ready holds the block at the emit step of the next evaluation until it is taken.
`include "av1_skip_mode_reference_search_macros.svh"

module av1_skip_mode_reference_search
    import av1_smrs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [SLOT_W-1:0]     s_slot,
    input  logic [HINT_W-1:0]     s_slot_hint,
    input  logic [HINT_W-1:0]     s_current_hint,
    input  logic                  s_intra_frame,
    input  logic                  s_compound_select,
    input  logic [SLOT_W-1:0]     s_ref_pick_0,
    input  logic [SLOT_W-1:0]     s_ref_pick_1,
    input  logic [SLOT_W-1:0]     s_ref_pick_2,
    input  logic [SLOT_W-1:0]     s_ref_pick_3,
    input  logic [SLOT_W-1:0]     s_ref_pick_4,
    input  logic [2*SLOT_W-1:0]   s_ref_pick_5_6,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_skip_allowed,
    output logic                  m_forward_found,
    output logic [POS_W-1:0]      m_forward_pos,
    output logic                  m_backward_found,
    output logic [POS_W-1:0]      m_backward_pos,
    output logic                  m_second_found,
    output logic [POS_W-1:0]      m_second_pos
);

    logic                  order_hint_enable_reg;
    logic [CFG_DATA_W-1:0] hint_bits_reg;

    logic [HINT_W-1:0] hint_reg [NUM_SLOTS];
    logic [SLOT_W-1:0] pick_reg [NUM_PICKS];
    logic [HINT_W-1:0] cur_reg;
    logic              off_reg;
    logic [POS_W-1:0]  idx_reg;
    logic [POS_W-1:0]  idx_next;

    logic              fwd_found_reg, fwd_found_next;
    logic              bwd_found_reg, bwd_found_next;
    logic              sec_found_reg, sec_found_next;
    logic [POS_W-1:0]  fwd_pos_reg, bwd_pos_reg, sec_pos_reg;
    logic [HINT_W-1:0] fwd_h_reg, bwd_h_reg, sec_h_reg;

    logic              m_valid_reg, m_valid_next;
    logic              m_skip_allowed_reg;
    logic              m_forward_found_reg, m_backward_found_reg, m_second_found_reg;
    logic [POS_W-1:0]  m_forward_pos_reg, m_backward_pos_reg, m_second_pos_reg;

    useq_flags_t flags;
    uword_t      ctrl;

    logic                     accept;
    logic                     start;
    logic                     load;
    logic                     scanning;
    logic                     out_busy;
    logic                     emit_fire;
    logic [CFG_DATA_W-1:0]    eff_bits;
    logic [SLOT_W-1:0]        pick;
    logic [HINT_W-1:0]        scan_hint;
    logic [HINT_W-1:0]        alt_h;
    logic signed [HINT_W:0]   d_cur, d_fwd, d_alt;
    logic                     upd_fwd, upd_bwd, upd_sec;

    av1_smrs_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    assign s_ready   = (ctrl.op == OP_IDLE);
    assign accept    = s_valid && s_ready;
    assign start     = accept && s_action;
    assign load      = accept && !s_action;
    assign scanning  = (ctrl.op == OP_SCAN1) || (ctrl.op == OP_SCAN2);
    assign out_busy  = m_valid_reg && !m_ready;
    assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

    assign flags.start    = start;
    assign flags.off      = off_reg;
    assign flags.more     = (idx_reg != POS_W'(NUM_REFS - 1));
    assign flags.no_scan2 = bwd_found_reg || !fwd_found_reg;
    assign flags.out_busy = out_busy;

    always_comb begin
        if (hint_bits_reg == '0) begin
            eff_bits = CFG_DATA_W'(1);
        end else if (hint_bits_reg > CFG_DATA_W'(MAX_HINT_BITS)) begin
            eff_bits = CFG_DATA_W'(MAX_HINT_BITS);
        end else begin
            eff_bits = hint_bits_reg;
        end

        pick = pick_reg[idx_reg];
        if ({1'b0, pick} < (SLOT_W+1)'(NUM_SLOTS)) begin
            scan_hint = hint_reg[pick[SLOT_IDX_W-1:0]];
        end else begin
            scan_hint = '0;
        end

        alt_h = (ctrl.op == OP_SCAN1) ? bwd_h_reg : sec_h_reg;
        d_cur = rel_dist(scan_hint, cur_reg, eff_bits);
        d_fwd = rel_dist(scan_hint, fwd_h_reg, eff_bits);
        d_alt = rel_dist(scan_hint, alt_h, eff_bits);

        upd_fwd = (ctrl.op == OP_SCAN1) && d_cur[HINT_W]
                  && (!fwd_found_reg || (!d_fwd[HINT_W] && d_fwd != '0));
        upd_bwd = (ctrl.op == OP_SCAN1) && !d_cur[HINT_W] && (d_cur != '0)
                  && (!bwd_found_reg || d_alt[HINT_W]);
        upd_sec = (ctrl.op == OP_SCAN2) && d_fwd[HINT_W]
                  && (!sec_found_reg || (!d_alt[HINT_W] && d_alt != '0));

        idx_next       = (scanning && flags.more) ? idx_reg + POS_W'(1) : '0;
        fwd_found_next = start ? 1'b0 : (fwd_found_reg || upd_fwd);
        bwd_found_next = start ? 1'b0 : (bwd_found_reg || upd_bwd);
        sec_found_next = start ? 1'b0 : (sec_found_reg || upd_sec);

        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_hint_enable_reg <= 1'b1;
            hint_bits_reg         <= CFG_DATA_W'(MAX_HINT_BITS);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                hint_reg[i] <= '0;
            end
            idx_reg       <= '0;
            off_reg       <= 1'b0;
            fwd_found_reg <= 1'b0;
            bwd_found_reg <= 1'b0;
            sec_found_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_ORDER_HINT_ENABLE: order_hint_enable_reg <= cfg_data[0];
                    REG_HINT_BITS:         hint_bits_reg         <= cfg_data;
                    default:               hint_bits_reg         <= hint_bits_reg;
                endcase
            end
            if (load && ({1'b0, s_slot} < (SLOT_W+1)'(NUM_SLOTS))) begin
                hint_reg[s_slot[SLOT_IDX_W-1:0]] <= s_slot_hint;
            end
            if (start) begin
                off_reg <= s_intra_frame || !s_compound_select || !order_hint_enable_reg;
            end
            idx_reg       <= idx_next;
            fwd_found_reg <= fwd_found_next;
            bwd_found_reg <= bwd_found_next;
            sec_found_reg <= sec_found_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cur_reg     <= s_current_hint;
            pick_reg[0] <= s_ref_pick_0;
            pick_reg[1] <= s_ref_pick_1;
            pick_reg[2] <= s_ref_pick_2;
            pick_reg[3] <= s_ref_pick_3;
            pick_reg[4] <= s_ref_pick_4;
            pick_reg[5] <= s_ref_pick_5_6[SLOT_W-1:0];
            pick_reg[6] <= s_ref_pick_5_6[2*SLOT_W-1:SLOT_W];
        end
        if (upd_fwd) begin
            fwd_pos_reg <= idx_reg;
            fwd_h_reg   <= scan_hint;
        end
        if (upd_bwd) begin
            bwd_pos_reg <= idx_reg;
            bwd_h_reg   <= scan_hint;
        end
        if (upd_sec) begin
            sec_pos_reg <= idx_reg;
            sec_h_reg   <= scan_hint;
        end
        if (emit_fire) begin
            m_skip_allowed_reg   <= fwd_found_reg && (bwd_found_reg || sec_found_reg);
            m_forward_found_reg  <= fwd_found_reg;
            m_forward_pos_reg    <= fwd_found_reg ? fwd_pos_reg : '0;
            m_backward_found_reg <= bwd_found_reg;
            m_backward_pos_reg   <= bwd_found_reg ? bwd_pos_reg : '0;
            m_second_found_reg   <= sec_found_reg;
            m_second_pos_reg     <= sec_found_reg ? sec_pos_reg : '0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_skip_allowed   = m_skip_allowed_reg;
    assign m_forward_found  = m_forward_found_reg;
    assign m_forward_pos    = m_forward_pos_reg;
    assign m_backward_found = m_backward_found_reg;
    assign m_backward_pos   = m_backward_pos_reg;
    assign m_second_found   = m_second_found_reg;
    assign m_second_pos     = m_second_pos_reg;

    `SMRS_ASSERT(a_skip_fwd, m_valid && m_skip_allowed |-> m_forward_found, "no forward ref")
    `SMRS_ASSERT(a_no_sec_bwd, m_valid |-> !(m_backward_found && m_second_found), "sec with bwd")
    `SMRS_ASSERT_NEXT(a_eval_busy, s_valid && s_ready && s_action, !s_ready, "no search started")

endmodule
